[rtl/core/triangle_face_normal_unit_defines.svh]
// Assertion macros for the triangle face normal unit.
// Used by files that assert; expects clk and rst_n in scope.
`ifndef TRIANGLE_FACE_NORMAL_UNIT_DEFINES_SVH
`define TRIANGLE_FACE_NORMAL_UNIT_DEFINES_SVH

// Same-cycle implication, checked out of reset
`define TFN_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked out of reset
`define TFN_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

[rtl/core/tfn_pkg.sv]
// Shared types and constants of the triangle face normal unit.
// No dependencies.
package tfn_pkg;

  localparam int COORD_WIDTH_DEF      = 16;
  localparam int NORMAL_FRAC_BITS_DEF = 14;
  localparam int FIELD_W              = 16;
  // the largest normalized magnitude sits in [2^29, 2^30)
  localparam int MAG_W                = 30;
  localparam int SUM_W                = 2 * MAG_W + 2;
  localparam int ROOT_W               = MAG_W + 1;

  typedef logic [2:0][MAG_W-1:0] mag3_t;

  // sideband that travels with every item
  typedef struct packed {
    logic               vld;
    logic               pass;
    logic               zero;
    logic [2:0]         neg;
    logic [FIELD_W-1:0] gx;
    logic [FIELD_W-1:0] gy;
    logic [FIELD_W-1:0] gz;
  } side_t;

endpackage

[rtl/core/tfn_front.sv]
// Edge vectors and cross product, three register stages.
// Depends on tfn_pkg.
module tfn_front #(
  parameter int COORD_WIDTH = tfn_pkg::COORD_WIDTH_DEF,
  parameter int NW          = 2 * (((COORD_WIDTH < 16) ? COORD_WIDTH : 16) + 1) + 1
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              en,
  input  logic [8:0][tfn_pkg::FIELD_W-1:0]  crd_i,
  input  tfn_pkg::side_t                    side_i,
  output logic [2:0][NW-1:0]                n_o,
  output tfn_pkg::side_t                    side_o
);
  import tfn_pkg::*;

  localparam int UW = (COORD_WIDTH < 16) ? COORD_WIDTH : 16;
  localparam int EW = UW + 1;
  localparam int PW = 2 * EW;

  // coordinate as read at COORD_WIDTH bits; wider widths see a zero top
  function automatic logic signed [EW-1:0] ext(input logic [FIELD_W-1:0] raw);
    logic [UW-1:0] v;
    v = raw[UW-1:0];
    if (COORD_WIDTH <= 16) return $signed({v[UW-1], v});
    else return $signed({1'b0, v});
  endfunction

  logic signed [EW-1:0] e_r [6];
  logic signed [PW-1:0] p_r [6];
  logic [2:0][NW-1:0]   n_r;
  side_t                s1_r, s2_r, s3_r;

  // stage 1: edges U = B - A, V = C - A
  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        e_r[i]     <= ext(crd_i[3+i]) - ext(crd_i[i]);
        e_r[3 + i] <= ext(crd_i[6+i]) - ext(crd_i[i]);
      end
    end
  end

  // stage 2: six partial products
  always_ff @(posedge clk) begin
    if (en) begin
      p_r[0] <= e_r[1] * e_r[5];
      p_r[1] <= e_r[2] * e_r[4];
      p_r[2] <= e_r[2] * e_r[3];
      p_r[3] <= e_r[0] * e_r[5];
      p_r[4] <= e_r[0] * e_r[4];
      p_r[5] <= e_r[1] * e_r[3];
    end
  end

  // stage 3: cross product components
  always_ff @(posedge clk) begin
    if (en) begin
      n_r[0] <= NW'(p_r[0]) - NW'(p_r[1]);
      n_r[1] <= NW'(p_r[2]) - NW'(p_r[3]);
      n_r[2] <= NW'(p_r[4]) - NW'(p_r[5]);
    end
  end

  // sideband
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_r <= '0;
      s2_r <= '0;
      s3_r <= '0;
    end else if (en) begin
      s1_r <= side_i;
      s2_r <= s1_r;
      s3_r <= s2_r;
    end
  end

  assign n_o    = n_r;
  assign side_o = s3_r;

endmodule

[rtl/core/tfn_norm.sv]
// Block normalization and sum of squares, five register stages.
// Depends on tfn_pkg.
module tfn_norm #(
  parameter int NW = 35
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      en,
  input  logic [2:0][NW-1:0]        n_i,
  input  tfn_pkg::side_t            side_i,
  output logic [tfn_pkg::SUM_W-1:0] sum_o,
  output tfn_pkg::mag3_t            mag_o,
  output tfn_pkg::side_t            side_o
);
  import tfn_pkg::*;

  localparam int TW  = (NW > MAG_W) ? NW : MAG_W;
  localparam int PSW = $clog2(NW);
  localparam int SAW = $clog2(TW + 1);
  localparam int TOPB = MAG_W - 1;

  logic [2:0][NW-1:0]  ma_r, mb_r;
  logic [NW-1:0]       big_r;
  logic                right_r;
  logic [SAW-1:0]      amt_r;
  mag3_t               mc_r, md_r, me_r;
  logic [2*MAG_W-1:0]  sq_r [3];
  logic [SUM_W-1:0]    sum_r;
  side_t               sa_r, sb_r, sc_r, sd_r, se_r;

  logic [2:0][NW-1:0]  mag;
  logic [NW-1:0]       big;
  logic [PSW-1:0]      pos;
  mag3_t               shf;
  side_t               side_a;

  // stage A: magnitudes, signs, largest component
  always_comb begin
    big = '0;
    for (int i = 0; i < 3; i++) begin
      mag[i] = n_i[i][NW-1] ? (~n_i[i] + 1'b1) : n_i[i];
      if (mag[i] > big) big = mag[i];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ma_r  <= mag;
      big_r <= big;
    end
  end

  // stage B: leading one of the largest component gives the common shift
  always_comb begin
    pos = '0;
    for (int i = 0; i < NW; i++) begin
      if (big_r[i]) pos = PSW'(i);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      mb_r    <= ma_r;
      right_r <= (int'(pos) >= TOPB);
      amt_r   <= (int'(pos) >= TOPB) ? SAW'(int'(pos) - TOPB) : SAW'(TOPB - int'(pos));
    end
  end

  // stage C: shift all three by the same amount
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      logic [TW-1:0] t;
      t = TW'(mb_r[i]);
      t = right_r ? (t >> amt_r) : (t << amt_r);
      shf[i] = t[MAG_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en) mc_r <= shf;
  end

  // stage D: squares
  always_ff @(posedge clk) begin
    if (en) begin
      md_r <= mc_r;
      for (int i = 0; i < 3; i++) sq_r[i] <= mc_r[i] * mc_r[i];
    end
  end

  // stage E: sum of squares
  always_ff @(posedge clk) begin
    if (en) begin
      me_r  <= md_r;
      sum_r <= SUM_W'(sq_r[0]) + SUM_W'(sq_r[1]) + SUM_W'(sq_r[2]);
    end
  end

  // sideband; zero and signs are known in stage A
  always_comb begin
    side_a      = side_i;
    side_a.zero = (big == '0);
    side_a.neg  = {n_i[2][NW-1], n_i[1][NW-1], n_i[0][NW-1]};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sa_r <= '0;
      sb_r <= '0;
      sc_r <= '0;
      sd_r <= '0;
      se_r <= '0;
    end else if (en) begin
      sa_r <= side_a;
      sb_r <= sa_r;
      sc_r <= sb_r;
      sd_r <= sc_r;
      se_r <= sd_r;
    end
  end

  assign sum_o  = sum_r;
  assign mag_o  = me_r;
  assign side_o = se_r;

endmodule

[rtl/core/tfn_sqrt.sv]
// Integer square root, one root bit per register stage.
// Depends on tfn_pkg.
module tfn_sqrt (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       en,
  input  logic [tfn_pkg::SUM_W-1:0]  sum_i,
  input  tfn_pkg::mag3_t             mag_i,
  input  tfn_pkg::side_t             side_i,
  output logic [tfn_pkg::ROOT_W-1:0] root_o,
  output tfn_pkg::mag3_t             mag_o,
  output tfn_pkg::side_t             side_o
);
  import tfn_pkg::*;

  localparam int RW = ROOT_W + 2;

  logic [SUM_W-1:0]  x_r    [ROOT_W];
  logic [RW-1:0]     rem_r  [ROOT_W];
  logic [ROOT_W-1:0] root_r [ROOT_W];
  mag3_t             mag_r  [ROOT_W];
  side_t             side_r [ROOT_W];

  for (genvar k = 0; k < ROOT_W; k++) begin : g_stage
    logic [SUM_W-1:0]  x_in;
    logic [RW-1:0]     rem_in;
    logic [ROOT_W-1:0] root_in;
    mag3_t             mag_in;
    side_t             side_in;
    logic [RW+1:0]     cand;
    logic [RW+1:0]     trial;

    if (k == 0) begin : g_first
      assign x_in    = sum_i;
      assign rem_in  = '0;
      assign root_in = '0;
      assign mag_in  = mag_i;
      assign side_in = side_i;
    end else begin : g_next
      assign x_in    = x_r[k-1];
      assign rem_in  = rem_r[k-1];
      assign root_in = root_r[k-1];
      assign mag_in  = mag_r[k-1];
      assign side_in = side_r[k-1];
    end

    // bring down the next two bits and try root*4+1
    assign cand  = {rem_in, x_in[SUM_W-1 -: 2]};
    assign trial = (RW+2)'({root_in, 2'b01});

    always_ff @(posedge clk) begin
      if (en) begin
        x_r[k]   <= {x_in[SUM_W-3:0], 2'b00};
        mag_r[k] <= mag_in;
        if (cand >= trial) begin
          rem_r[k]  <= RW'(cand - trial);
          root_r[k] <= {root_in[ROOT_W-2:0], 1'b1};
        end else begin
          rem_r[k]  <= RW'(cand);
          root_r[k] <= {root_in[ROOT_W-2:0], 1'b0};
        end
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        side_r[k] <= '0;
      end else if (en) begin
        side_r[k] <= side_in;
      end
    end
  end

  assign root_o = root_r[ROOT_W-1];
  assign mag_o  = mag_r[ROOT_W-1];
  assign side_o = side_r[ROOT_W-1];

endmodule

[rtl/core/tfn_div.sv]
// Three-lane rounded division m*2^F/L, one quotient bit per stage.
// Depends on tfn_pkg.
module tfn_div #(
  parameter int NORMAL_FRAC_BITS = tfn_pkg::NORMAL_FRAC_BITS_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       en,
  input  logic [tfn_pkg::ROOT_W-1:0] len_i,
  input  tfn_pkg::mag3_t             mag_i,
  input  tfn_pkg::side_t             side_i,
  output logic [2:0][NORMAL_FRAC_BITS+1:0] q_o,
  output tfn_pkg::side_t             side_o
);
  import tfn_pkg::*;

  localparam int QB = NORMAL_FRAC_BITS + 2;
  localparam int RW = ROOT_W + QB;

  logic [2:0][RW-1:0] d_r;
  logic [ROOT_W-1:0]  len_r;
  side_t              s0_r;

  logic [2:0][RW-1:0] rem_r [QB];
  logic [2:0][QB-1:0] q_r   [QB];
  logic [ROOT_W-1:0]  l_r   [QB];
  side_t              side_r [QB];

  // dividend with half the divisor added for round half up
  always_ff @(posedge clk) begin
    if (en) begin
      len_r <= len_i;
      for (int i = 0; i < 3; i++) begin
        d_r[i] <= (RW'(mag_i[i]) << NORMAL_FRAC_BITS) + RW'(len_i >> 1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_r <= '0;
    end else if (en) begin
      s0_r <= side_i;
    end
  end

  for (genvar k = 0; k < QB; k++) begin : g_stage
    localparam int J = QB - 1 - k;
    logic [2:0][RW-1:0] rem_in;
    logic [2:0][QB-1:0] q_in;
    logic [ROOT_W-1:0]  l_in;
    side_t              side_in;
    logic [RW-1:0]      dvs;

    if (k == 0) begin : g_first
      assign rem_in  = d_r;
      assign q_in    = '0;
      assign l_in    = len_r;
      assign side_in = s0_r;
    end else begin : g_next
      assign rem_in  = rem_r[k-1];
      assign q_in    = q_r[k-1];
      assign l_in    = l_r[k-1];
      assign side_in = side_r[k-1];
    end

    assign dvs = RW'(l_in) << J;

    // restoring step, lanes side by side
    always_ff @(posedge clk) begin
      if (en) begin
        l_r[k] <= l_in;
        for (int i = 0; i < 3; i++) begin
          if (rem_in[i] >= dvs) begin
            rem_r[k][i] <= rem_in[i] - dvs;
            q_r[k][i]   <= {q_in[i][QB-2:0], 1'b1};
          end else begin
            rem_r[k][i] <= rem_in[i];
            q_r[k][i]   <= {q_in[i][QB-2:0], 1'b0};
          end
        end
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        side_r[k] <= '0;
      end else if (en) begin
        side_r[k] <= side_in;
      end
    end
  end

  assign q_o    = q_r[QB-1];
  assign side_o = side_r[QB-1];

endmodule

[rtl/core/triangle_face_normal_unit.sv]
// Triangle face normal unit: top level, output register and stall control.
// Depends on tfn_pkg, tfn_front, tfn_norm, tfn_sqrt, tfn_div and the defines header.
//
// Takes one triangle per cycle while in_ready is high and returns one normal per triangle, in order.
// A stored normal that is not all zero passes through with out_replaced low;
// otherwise the face normal of (B-A) x (C-A) is scaled to unit length and
// rounded half up to NORMAL_FRAC_BITS fraction bits, with out_replaced high.
// A degenerate triangle with no stored normal returns a zero normal with out_replaced high.
// The pipeline runs through edges and cross product, normalization and
// squares, the bit-per-stage square root, the bit-per-stage divider and
// the output register. The whole pipeline holds while a result waits in
// the output register and out_ready is low.
`include "triangle_face_normal_unit_defines.svh"

module triangle_face_normal_unit #(
  parameter int COORD_WIDTH      = tfn_pkg::COORD_WIDTH_DEF,
  parameter int NORMAL_FRAC_BITS = tfn_pkg::NORMAL_FRAC_BITS_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [tfn_pkg::FIELD_W-1:0] in_a_x,
  input  logic [tfn_pkg::FIELD_W-1:0] in_a_y,
  input  logic [tfn_pkg::FIELD_W-1:0] in_a_z,
  input  logic [tfn_pkg::FIELD_W-1:0] in_b_x,
  input  logic [tfn_pkg::FIELD_W-1:0] in_b_y,
  input  logic [tfn_pkg::FIELD_W-1:0] in_b_z,
  input  logic [tfn_pkg::FIELD_W-1:0] in_c_x,
  input  logic [tfn_pkg::FIELD_W-1:0] in_c_y,
  input  logic [tfn_pkg::FIELD_W-1:0] in_c_z,
  input  logic [tfn_pkg::FIELD_W-1:0] in_given_nx,
  input  logic [tfn_pkg::FIELD_W-1:0] in_given_ny,
  input  logic [tfn_pkg::FIELD_W-1:0] in_given_nz,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [tfn_pkg::FIELD_W-1:0] out_nx,
  output logic [tfn_pkg::FIELD_W-1:0] out_ny,
  output logic [tfn_pkg::FIELD_W-1:0] out_nz,
  output logic                        out_replaced
);
  import tfn_pkg::*;

  localparam int UW = (COORD_WIDTH < 16) ? COORD_WIDTH : 16;
  localparam int NW = 2 * (UW + 1) + 1;
  localparam int QB = NORMAL_FRAC_BITS + 2;

  logic                    en;
  side_t                   side0, side_f, side_n, side_s, side_d;
  logic [8:0][FIELD_W-1:0] crd;
  logic [2:0][NW-1:0]      n_w;
  logic [SUM_W-1:0]        sum_w;
  mag3_t                   mag_n, mag_s;
  logic [ROOT_W-1:0]       root_w;
  logic [2:0][QB-1:0]      q_w;
  logic [2:0][FIELD_W-1:0] res;

  logic                    out_valid_r;
  logic [FIELD_W-1:0]      out_nx_r, out_ny_r, out_nz_r;
  logic                    out_replaced_r;
  logic                    out_stall;
  logic                    out_nonzero;

  // pipeline moves unless a result is stuck in the output register
  assign en       = !out_valid_r || out_ready;
  assign in_ready = en;

  assign crd = {in_c_z, in_c_y, in_c_x, in_b_z, in_b_y, in_b_x, in_a_z, in_a_y, in_a_x};

  always_comb begin
    side0      = '0;
    side0.vld  = in_valid;
    side0.pass = (in_given_nx != '0) || (in_given_ny != '0) || (in_given_nz != '0);
    side0.gx   = in_given_nx;
    side0.gy   = in_given_ny;
    side0.gz   = in_given_nz;
  end

  tfn_front #(.COORD_WIDTH(COORD_WIDTH), .NW(NW)) u_front (
    .clk(clk), .rst_n(rst_n), .en(en),
    .crd_i(crd), .side_i(side0), .n_o(n_w), .side_o(side_f)
  );

  tfn_norm #(.NW(NW)) u_norm (
    .clk(clk), .rst_n(rst_n), .en(en),
    .n_i(n_w), .side_i(side_f), .sum_o(sum_w), .mag_o(mag_n), .side_o(side_n)
  );

  tfn_sqrt u_sqrt (
    .clk(clk), .rst_n(rst_n), .en(en),
    .sum_i(sum_w), .mag_i(mag_n), .side_i(side_n),
    .root_o(root_w), .mag_o(mag_s), .side_o(side_s)
  );

  tfn_div #(.NORMAL_FRAC_BITS(NORMAL_FRAC_BITS)) u_div (
    .clk(clk), .rst_n(rst_n), .en(en),
    .len_i(root_w), .mag_i(mag_s), .side_i(side_s), .q_o(q_w), .side_o(side_d)
  );

  // cap at one, apply sign, fit to the field
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      logic [QB-1:0]     qc;
      logic signed [QB:0] sq;
      qc = (q_w[i] > (QB'(1) << NORMAL_FRAC_BITS)) ? (QB'(1) << NORMAL_FRAC_BITS) : q_w[i];
      sq = side_d.neg[i] ? -$signed({1'b0, qc}) : $signed({1'b0, qc});
      res[i] = side_d.zero ? '0 : FIELD_W'(sq);
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= side_d.vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_nx_r       <= side_d.pass ? side_d.gx : res[0];
      out_ny_r       <= side_d.pass ? side_d.gy : res[1];
      out_nz_r       <= side_d.pass ? side_d.gz : res[2];
      out_replaced_r <= !side_d.pass;
    end
  end

  assign out_valid    = out_valid_r;
  assign out_nx       = out_nx_r;
  assign out_ny       = out_ny_r;
  assign out_nz       = out_nz_r;
  assign out_replaced = out_replaced_r;

  // checks
  assign out_stall   = out_valid && !out_ready;
  assign out_nonzero = |{out_nx, out_ny, out_nz};

  `TFN_ASSERT_IMP(a_stall_when_full, !in_ready, out_stall, "stall without waiting result")
  `TFN_ASSERT_IMP(a_pass_nonzero, out_valid && !out_replaced, out_nonzero, "passed normal is zero")
  `TFN_ASSERT_NXT(a_held_result, out_stall, out_valid && $stable(out_replaced), "result lost")

endmodule

[tb/tb_triangle_face_normal_unit.sv]
// Testbench for triangle_face_normal_unit: directed and random triangles,
// checked item by item against an in-bench face normal predictor.
// Depends on tfn_pkg and the triangle_face_normal_unit RTL.
`timescale 1ns / 100ps

module tb_triangle_face_normal_unit;
  import tfn_pkg::*;

  localparam int FRAC     = NORMAL_FRAC_BITS_DEF;
  localparam int LATENCY  = FRAC + 43;
  localparam int N_RANDOM = 175;

  // 0..8 are A, B, C coordinates (x, y, z each), 9..11 the stored normal
  typedef logic [11:0][FIELD_W-1:0] triangle_t;

  typedef struct {
    logic [FIELD_W-1:0] nx;
    logic [FIELD_W-1:0] ny;
    logic [FIELD_W-1:0] nz;
    logic               replaced;
  } normal_t;

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_ready;
  triangle_t in_tri;
  logic out_valid;
  logic out_ready;
  logic [FIELD_W-1:0] out_nx;
  logic [FIELD_W-1:0] out_ny;
  logic [FIELD_W-1:0] out_nz;
  logic out_replaced;

  normal_t expected_normals[$];
  int mismatch_count;
  int sent_count;
  int checked_count;
  int replaced_count;
  int sender_idle_pct;
  int receiver_idle_pct;

  triangle_face_normal_unit i_dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_a_x       (in_tri[0]),
    .in_a_y       (in_tri[1]),
    .in_a_z       (in_tri[2]),
    .in_b_x       (in_tri[3]),
    .in_b_y       (in_tri[4]),
    .in_b_z       (in_tri[5]),
    .in_c_x       (in_tri[6]),
    .in_c_y       (in_tri[7]),
    .in_c_z       (in_tri[8]),
    .in_given_nx  (in_tri[9]),
    .in_given_ny  (in_tri[10]),
    .in_given_nz  (in_tri[11]),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_nx       (out_nx),
    .out_ny       (out_ny),
    .out_nz       (out_nz),
    .out_replaced (out_replaced)
  );

  // clock
  initial clk = 1'b0;
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Predicted normal of one triangle
  function automatic normal_t face_normal(triangle_t t);
    normal_t r;
    longint e[6];
    longint n[3];
    longint unsigned m[3];
    longint unsigned big, sum, root, bitv, q;
    logic [FIELD_W-1:0] v;
    int i;
    if ((t[9] | t[10] | t[11]) != '0) begin
      r.nx = t[9];
      r.ny = t[10];
      r.nz = t[11];
      r.replaced = 1'b0;
      return r;
    end
    for (i = 0; i < 3; i++) begin
      e[i]     = longint'($signed(t[3+i])) - longint'($signed(t[i]));
      e[3 + i] = longint'($signed(t[6+i])) - longint'($signed(t[i]));
    end
    n[0] = e[1] * e[5] - e[2] * e[4];
    n[1] = e[2] * e[3] - e[0] * e[5];
    n[2] = e[0] * e[4] - e[1] * e[3];
    big = 0;
    for (i = 0; i < 3; i++) begin
      m[i] = (n[i] < 0) ? longint'(-n[i]) : longint'(n[i]);
      if (m[i] > big) big = m[i];
    end
    r.replaced = 1'b1;
    r.nx = '0;
    r.ny = '0;
    r.nz = '0;
    if (big == 0) return r;
    // common shift so the largest magnitude sits in [2^29, 2^30)
    while (big >= (64'd1 << 30)) begin
      big = big >> 1;
      for (i = 0; i < 3; i++) m[i] = m[i] >> 1;
    end
    while (big < (64'd1 << 29)) begin
      big = big << 1;
      for (i = 0; i < 3; i++) m[i] = m[i] << 1;
    end
    sum = m[0] * m[0] + m[1] * m[1] + m[2] * m[2];
    // exact integer square root
    root = 0;
    bitv = 64'd1 << 62;
    while (bitv > sum) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (sum >= root + bitv) begin
        sum = sum - (root + bitv);
        root = (root >> 1) + bitv;
      end else begin
        root = root >> 1;
      end
      bitv = bitv >> 2;
    end
    for (i = 0; i < 3; i++) begin
      q = ((m[i] << FRAC) + (root >> 1)) / root;
      if (q > (64'd1 << FRAC)) q = 64'd1 << FRAC;
      v = q[FIELD_W-1:0];
      if (n[i] < 0) v = -v;
      case (i)
        0: r.nx = v;
        1: r.ny = v;
        default: r.nz = v;
      endcase
    end
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [FIELD_W-1:0] want,
                                 logic [FIELD_W-1:0] got);
    $display("[%0t] mismatch on %s: expected %h, got %h", $realtime, what, want, got);
    mismatch_count++;
  endtask

  // Send one triangle; valid stays high through the acceptance edge
  task automatic send_triangle(triangle_t t);
    while ($urandom_range(99) < sender_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_tri   <= t;
    in_valid <= 1'b1;
    do @(posedge clk); while (!in_ready);
    expected_normals.insert(expected_normals.size(), face_normal(t));
    sent_count++;
  endtask

  // Receiver stalls
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= receiver_idle_pct);
    end
  end

  // Result checker
  always @(posedge clk) begin
    normal_t want;
    if (rst_n && out_valid && out_ready) begin
      if (expected_normals.size() == 0) begin
        $display("[%0t] result with no item outstanding", $realtime);
        mismatch_count++;
      end else begin
        want = expected_normals.pop_front();
        if (out_nx !== want.nx) report_mismatch("out_nx", want.nx, out_nx);
        if (out_ny !== want.ny) report_mismatch("out_ny", want.ny, out_ny);
        if (out_nz !== want.nz) report_mismatch("out_nz", want.nz, out_nz);
        if (out_replaced !== want.replaced)
          report_mismatch("out_replaced", 16'(want.replaced), 16'(out_replaced));
        if (want.replaced) replaced_count++;
        checked_count++;
      end
    end
  end

  function automatic triangle_t make_tri(int ax, int ay, int az, int bx, int by, int bz,
                                         int cx, int cy, int cz, int gx, int gy, int gz);
    triangle_t t;
    t[0] = 16'(ax); t[1] = 16'(ay); t[2] = 16'(az);
    t[3] = 16'(bx); t[4] = 16'(by); t[5] = 16'(bz);
    t[6] = 16'(cx); t[7] = 16'(cy); t[8] = 16'(cz);
    t[9] = 16'(gx); t[10] = 16'(gy); t[11] = 16'(gz);
    return t;
  endfunction

  // Stored normal passes through, including out-of-range values
  task automatic test_passthrough();
    send_triangle(make_tri(0, 0, 0, 256, 0, 0, 0, 256, 0, 0, 0, 16384));
    send_triangle(make_tri(1, 2, 3, 4, 5, 6, 7, 8, 9, -16384, 0, 0));
    send_triangle(make_tri(0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 1, 0));
    send_triangle(make_tri(0, 0, 0, 0, 0, 0, 0, 0, 0, 32767, -32768, -1));
    send_triangle(make_tri(-32768, 32767, 0, 5, 5, 5, 9, 9, 9, 16384, 16384, 16384));
  endtask

  // Degenerate triangles give a zero normal with the flag set
  task automatic test_degenerate();
    send_triangle(make_tri(0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
    send_triangle(make_tri(100, -200, 300, 100, -200, 300, 100, -200, 300, 0, 0, 0));
    send_triangle(make_tri(0, 0, 0, 10, 20, 30, 20, 40, 60, 0, 0, 0));
    send_triangle(make_tri(-32768, -32768, -32768, 32767, 32767, 32767,
                           0, 0, 0, 0, 0, 0));
  endtask

  // Computed normals: axes, extremes, tiny and huge products
  task automatic test_computed();
    send_triangle(make_tri(0, 0, 0, 256, 0, 0, 0, 256, 0, 0, 0, 0));
    send_triangle(make_tri(0, 0, 0, 0, 256, 0, 256, 0, 0, 0, 0, 0));
    send_triangle(make_tri(0, 0, 0, 0, 0, 1, 1, 0, 0, 0, 0, 0));
    send_triangle(make_tri(0, 0, 0, 1, 0, 0, 0, 1, 0, 0, 0, 0));
    send_triangle(make_tri(-32768, -32768, -32768, 32767, -32768, -32768,
                           -32768, 32767, -32768, 0, 0, 0));
    send_triangle(make_tri(32767, 32767, 32767, -32768, 32767, 32767,
                           32767, 32767, -32768, 0, 0, 0));
    send_triangle(make_tri(-32768, 32767, -32768, 32767, -32768, 32767,
                           32767, 32767, -32768, 0, 0, 0));
    send_triangle(make_tri(0, 0, 0, 256, 256, 256, -256, 256, 0, 0, 0, 0));
    send_triangle(make_tri(10, 20, 30, 11, 20, 30, 10, 21, 31, 0, 0, 0));
    send_triangle(make_tri(0, 0, 0, 3, 4, 0, 0, 0, 5, 0, 0, 0));
    send_triangle(make_tri(-1, -1, -1, -2, -1, -1, -1, -2, -1, 0, 0, 0));
  endtask

  function automatic triangle_t random_triangle();
    triangle_t t;
    int d[3];
    int i;
    int kind;
    kind = $urandom_range(9);
    for (i = 0; i < 12; i++) t[i] = 16'($urandom());
    case (kind)
      0, 1, 2, 3: ;                         // full-range coordinates
      4, 5, 6: begin                        // small triangle near A
        for (i = 0; i < 3; i++) begin
          t[3 + i] = t[i] + 16'($signed($urandom_range(64)) - 32);
          t[6 + i] = t[i] + 16'($signed($urandom_range(64)) - 32);
        end
      end
      7: begin                              // collinear
        for (i = 0; i < 3; i++) begin
          d[i] = $urandom_range(200) - 100;
          t[i] = 16'($urandom_range(20000) - 10000);
          t[3 + i] = t[i] + 16'(d[i]);
          t[6 + i] = t[i] + 16'(2 * d[i]);
        end
      end
      default: ;
    endcase
    // stored normal: mostly zero, otherwise random or in range
    case ($urandom_range(9))
      0: ;
      1: begin
        t[9] = 16'($urandom_range(32768) - 16384);
        t[10] = '0;
        t[11] = 16'($urandom_range(32768) - 16384);
      end
      default: begin
        t[9] = '0; t[10] = '0; t[11] = '0;
      end
    endcase
    return t;
  endfunction

  task automatic test_random(int count, int s_idle, int r_idle);
    sender_idle_pct   = s_idle;
    receiver_idle_pct = r_idle;
    repeat (count) send_triangle(random_triangle());
  endtask

  // Sender holds off until the pipeline has fully drained
  task automatic test_drain_pause();
    repeat (5) send_triangle(random_triangle());
    in_valid <= 1'b0;
    while (expected_normals.size() != 0) @(posedge clk);
    repeat (5) send_triangle(random_triangle());
  endtask

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_tri = '0;
    mismatch_count = 0;
    sent_count = 0;
    checked_count = 0;
    replaced_count = 0;
    sender_idle_pct = 0;
    receiver_idle_pct = 0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_passthrough();
    test_degenerate();
    test_computed();
    test_random(N_RANDOM, 31, 74);
    test_drain_pause();
    test_random(N_RANDOM, 74, 31);
    test_random(N_RANDOM, 0, 0);
    in_valid <= 1'b0;

    while (expected_normals.size() != 0) @(posedge clk);
    repeat (LATENCY + 10) @(posedge clk);

    $display("Sent %0d triangles, checked %0d normals (%0d computed or degenerate),",
             sent_count, checked_count, replaced_count);
    $display("under sender and receiver stalls, a drain pause and full rate.");
    if (mismatch_count == 0 && expected_normals.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  // run limit
  initial begin
    #(12 * 400000);
    $display("Timeout with %0d normals outstanding", expected_normals.size());
    $display("*** FAILED ***");
    $finish;
  end

endmodule
